// ----- rtl/rsv_pkg.sv -----
// rsv_pkg: shared types, widths and constants of the linear resampler with volume.
// Used by every module of the block; depends on nothing.
package rsv_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PHASE_W    = 18;
	localparam int PHASE_FRAC = 16;
	localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC;

	localparam int MAX_OUT = 7;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int RATE_W     = 17;
	localparam int VOL_W      = 7;
	localparam int VOLQ_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_PERCENT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE    = 2'd2;

	localparam logic [RATE_W-1:0] RATE_RESET   = 17'd48000;
	localparam logic [VOL_W-1:0]  VOL_RESET    = 7'd100;
	localparam logic [VOL_W-1:0]  VOL_MAX      = 7'd100;
	localparam logic              STEREO_RESET = 1'b1;

	// step = rate*4096/3000 = rate*512/375, by exact reciprocal for 17-bit rates
	localparam int STEP_SHIFT   = 26;
	localparam int STEP_RECIP_W = 27;
	localparam longint unsigned STEP_RECIP_L =
		((64'd1 << (STEP_SHIFT + 9)) + 64'd374) / 64'd375;
	localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = STEP_RECIP_W'(STEP_RECIP_L);
	localparam logic [PHASE_W-1:0] STEP_RESET =
		PHASE_W'((longint'(RATE_RESET) * 4096) / 3000);

	// volq = vol*256/100 = vol*64/25, by exact reciprocal for 7-bit volumes
	localparam int VOL_SHIFT_Q  = 12;
	localparam int VOL_RECIP_W  = 14;
	localparam logic [VOL_RECIP_W-1:0] VOL_RECIP =
		VOL_RECIP_W'(((32'd1 << (VOL_SHIFT_Q + 6)) + 32'd24) / 32'd25);
	localparam logic [VOLQ_W-1:0] VOLQ_RESET = VOLQ_W'((int'(VOL_RESET) * 256) / 100);
	localparam int VOL_SHIFT = 8;

	// datapath widths
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int FRAC_W = PHASE_FRAC + 1;
	localparam int PROD_W = DIFF_W + FRAC_W;
	localparam int VQ_W   = VOLQ_W + 1;
	localparam int SCL_W  = SAMPLE_W + VQ_W;

	// frame queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       last_of_run;
	} result_t;

	typedef enum logic {
		KIND_PRIME,
		KIND_FRAME
	} kind_t;

	typedef struct packed {
		kind_t   kind;
		sample_t frame;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} head_t;

	typedef struct packed {
		logic [PHASE_W-1:0] step;
		logic [VOLQ_W-1:0]  volq;
		logic               stereo;
	} cfg_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_SCALE,
		B_EMIT
	} back_state_t;

endpackage

// ----- rtl/rsv_cfg.sv -----
// rsv_cfg: configuration registers and the derived phase step and volume factor.
// Depends on rsv_pkg.
module rsv_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [rsv_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [rsv_pkg::CFG_DATA_W-1:0]     cfg_data,
	output rsv_pkg::cfg_t                      cfg
);

	logic [rsv_pkg::RATE_W-1:0]  rate_q;
	logic [rsv_pkg::VOL_W-1:0]   vol_q;
	logic                        stereo_q;
	logic [rsv_pkg::PHASE_W-1:0] step_q;
	logic [rsv_pkg::VOLQ_W-1:0]  volq_q;

	logic [rsv_pkg::VOL_W-1:0]                       vol_clamped;
	logic [rsv_pkg::RATE_W+rsv_pkg::STEP_RECIP_W-1:0] step_prod;
	logic [rsv_pkg::VOL_W+rsv_pkg::VOL_RECIP_W-1:0]   volq_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= rsv_pkg::RATE_RESET;
			vol_q    <= rsv_pkg::VOL_RESET;
			stereo_q <= rsv_pkg::STEREO_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				rsv_pkg::REG_SOURCE_RATE:    rate_q   <= cfg_data[rsv_pkg::RATE_W-1:0];
				rsv_pkg::REG_VOLUME_PERCENT: vol_q    <= cfg_data[rsv_pkg::VOL_W-1:0];
				rsv_pkg::REG_STEREO_MODE:    stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign vol_clamped = (vol_q > rsv_pkg::VOL_MAX) ? rsv_pkg::VOL_MAX : vol_q;
	assign step_prod   = rate_q * rsv_pkg::STEP_RECIP;
	assign volq_prod   = vol_clamped * rsv_pkg::VOL_RECIP;

	// derived values follow the registers in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rsv_pkg::STEP_RESET;
			volq_q <= rsv_pkg::VOLQ_RESET;
		end else begin
			step_q <= step_prod[rsv_pkg::STEP_SHIFT +: rsv_pkg::PHASE_W];
			volq_q <= volq_prod[rsv_pkg::VOL_SHIFT_Q +: rsv_pkg::VOLQ_W];
		end
	end

	assign cfg.step   = step_q;
	assign cfg.volq   = volq_q;
	assign cfg.stereo = stereo_q;

endmodule

// ----- rtl/rsv_front.sv -----
// rsv_front: frame intake; tags the first frame after reset as priming and
// queues frames for the back end. Depends on rsv_pkg.
module rsv_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rsv_pkg::sample_t sample,
	output rsv_pkg::head_t   head,
	input  logic             head_pop
);

	rsv_pkg::qentry_t              mem_q [rsv_pkg::QDEPTH];
	logic [rsv_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [rsv_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [rsv_pkg::QCNT_W-1:0]    cnt_q;
	logic                          primed_q;
	logic                          wr;
	logic                          rd;
	rsv_pkg::qentry_t              entry;

	assign full  = (cnt_q == rsv_pkg::QCNT_W'(rsv_pkg::QDEPTH));
	assign wr    = push && !full;
	assign rd    = head_pop && (cnt_q != '0);

	assign entry.kind  = primed_q ? rsv_pkg::KIND_FRAME : rsv_pkg::KIND_PRIME;
	assign entry.frame = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				primed_q <= 1'b1;
			end
			if (rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= entry;
	end

	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

endmodule

// ----- rtl/rsv_back.sv -----
// rsv_back: per-frame sequencer and interpolate/scale datapath.
// Depends on rsv_pkg.
module rsv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rsv_pkg::cfg_t    cfg,
	input  rsv_pkg::head_t   head,
	output logic             head_pop,
	input  logic             oq_full,
	output logic             oq_wr,
	output rsv_pkg::result_t oq_data
);

	rsv_pkg::back_state_t state_q, state_n;

	logic signed [rsv_pkg::SAMPLE_W-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
	logic signed [rsv_pkg::PROD_W-1:0]   prod_l_q, prod_r_q;
	logic signed [rsv_pkg::SCL_W-1:0]    scl_l_q, scl_r_q;
	logic [rsv_pkg::PHASE_W-1:0]         phase_q;
	logic [rsv_pkg::CNT_W-1:0]           n_q;
	logic                                last_q;

	logic signed [rsv_pkg::DIFF_W-1:0]   diff_l, diff_r;
	logic signed [rsv_pkg::FRAC_W-1:0]   frac;
	logic signed [rsv_pkg::PROD_W-1:0]   mul_l, mul_r;
	logic signed [rsv_pkg::SAMPLE_W-1:0] ip_l, ip_r, ip_r_sel;
	logic signed [rsv_pkg::VQ_W-1:0]     vq;
	logic signed [rsv_pkg::SCL_W-1:0]    mul_sl, mul_sr;
	logic [rsv_pkg::PHASE_W-1:0]         phase_add, phase_wrap;
	logic [rsv_pkg::CNT_W-1:0]           n_next;
	logic                                head_go;
	logic                                do_mul, do_scale;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rsv_pkg::B_IDLE:  if (head_go) state_n = rsv_pkg::B_MUL;
			rsv_pkg::B_MUL:   state_n = rsv_pkg::B_SCALE;
			rsv_pkg::B_SCALE: state_n = rsv_pkg::B_EMIT;
			rsv_pkg::B_EMIT:  if (!oq_full) state_n = last_q ? rsv_pkg::B_IDLE : rsv_pkg::B_MUL;
			default:          state_n = rsv_pkg::B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		head_pop = (state_q == rsv_pkg::B_IDLE) && head.valid;
		do_mul   = (state_q == rsv_pkg::B_MUL);
		do_scale = (state_q == rsv_pkg::B_SCALE);
		oq_wr    = (state_q == rsv_pkg::B_EMIT) && !oq_full;
	end

	// frame that emits: primed and phase below one
	assign head_go = head.valid && (head.entry.kind == rsv_pkg::KIND_FRAME)
		&& (phase_q < rsv_pkg::PHASE_ONE);

	assign diff_l = rsv_pkg::DIFF_W'(cur_l_q) - rsv_pkg::DIFF_W'(prev_l_q);
	assign diff_r = rsv_pkg::DIFF_W'(cur_r_q) - rsv_pkg::DIFF_W'(prev_r_q);
	assign frac   = $signed({1'b0, phase_q[rsv_pkg::PHASE_FRAC-1:0]});
	assign mul_l  = diff_l * frac;
	assign mul_r  = diff_r * frac;

	assign ip_l = rsv_pkg::SAMPLE_W'(rsv_pkg::PROD_W'(prev_l_q)
		+ (prod_l_q >>> rsv_pkg::PHASE_FRAC));
	assign ip_r = rsv_pkg::SAMPLE_W'(rsv_pkg::PROD_W'(prev_r_q)
		+ (prod_r_q >>> rsv_pkg::PHASE_FRAC));
	assign ip_r_sel = cfg.stereo ? ip_r : ip_l;
	assign vq       = $signed({1'b0, cfg.volq});
	assign mul_sl   = ip_l * vq;
	assign mul_sr   = ip_r_sel * vq;

	assign phase_add  = phase_q + cfg.step;
	assign n_next     = n_q + 1'b1;
	assign phase_wrap = (phase_q < rsv_pkg::PHASE_ONE) ? '0 : phase_q - rsv_pkg::PHASE_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsv_pkg::B_IDLE;
			phase_q <= '0;
			n_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (head_pop) begin
				if (head.entry.kind == rsv_pkg::KIND_PRIME)
					phase_q <= '0;
				else if (!head_go)
					phase_q <= phase_q - rsv_pkg::PHASE_ONE;
				else
					n_q <= '0;
			end
			if (do_scale) begin
				phase_q <= phase_add;
				n_q     <= n_next;
				last_q  <= !((phase_add < rsv_pkg::PHASE_ONE)
					&& (n_next < rsv_pkg::CNT_W'(rsv_pkg::MAX_OUT)));
			end
			// after the last output: drop the run's overshoot or clear a capped run
			if (oq_wr && last_q)
				phase_q <= phase_wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			if (head_go) begin
				cur_l_q <= head.entry.frame.left_in;
				cur_r_q <= head.entry.frame.right_in;
			end else begin
				prev_l_q <= head.entry.frame.left_in;
				prev_r_q <= head.entry.frame.right_in;
			end
		end
		if (do_mul) begin
			prod_l_q <= mul_l;
			prod_r_q <= mul_r;
		end
		if (do_scale) begin
			scl_l_q <= mul_sl;
			scl_r_q <= mul_sr;
		end
		if (oq_wr && last_q) begin
			prev_l_q <= cur_l_q;
			prev_r_q <= cur_r_q;
		end
	end

	assign oq_data.left_out    = rsv_pkg::SAMPLE_W'(scl_l_q >>> rsv_pkg::VOL_SHIFT);
	assign oq_data.right_out   = rsv_pkg::SAMPLE_W'(scl_r_q >>> rsv_pkg::VOL_SHIFT);
	assign oq_data.last_of_run = last_q;

`ifndef SYNTHESIS
	a_mul_phase_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsv_pkg::B_MUL) |-> (phase_q < rsv_pkg::PHASE_ONE))
		else $error("interpolating with phase at or above one");
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsv_pkg::B_MUL) |-> (n_q < rsv_pkg::CNT_W'(rsv_pkg::MAX_OUT)))
		else $error("more outputs than allowed per frame");
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(oq_wr && last_q) |=> (state_q == rsv_pkg::B_IDLE))
		else $error("run did not end after last output");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rsv_pkg::B_IDLE) |-> !head_pop)
		else $error("frame taken while a run is in progress");
`endif

endmodule

// ----- rtl/rsv_outq.sv -----
// rsv_outq: two-entry result queue that decouples the back end from the reader.
// Depends on rsv_pkg.
module rsv_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  rsv_pkg::result_t wr_data,
	output logic             oq_full,
	input  logic             pop,
	output logic             empty,
	output rsv_pkg::result_t result
);

	rsv_pkg::result_t           mem_q [rsv_pkg::QDEPTH];
	logic [rsv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rsv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rsv_pkg::QCNT_W-1:0] cnt_q;
	logic                       do_wr;
	logic                       do_rd;

	assign oq_full = (cnt_q == rsv_pkg::QCNT_W'(rsv_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !oq_full;
	assign do_rd   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	assign result = mem_q[rd_ptr_q];

endmodule

// ----- rtl/linear_resampler_with_volume_top.sv -----
// linear_resampler_with_volume_top: linear interpolation resampler with volume.
// Instantiates rsv_cfg, rsv_front, rsv_back and rsv_outq; depends on rsv_pkg.
//
//   channel   ports                          transaction when
//   ------    -----------------------------  -----------------------------
//   config    cfg_wen, cfg_addr, cfg_data    cfg_wen high
//   input     push, full, sample             push high and full low
//   result    empty, pop, result             pop high and empty low
//
// A priming frame, or a frame arriving with phase at or above one, is consumed in
// the idle state without output. An emitting frame gives n outputs (at most
// seven): each output runs interpolate multiply, scale multiply, then result write,
// with separate interpolate and scale multipliers per channel. Derived step and volume
// follow a register write in the next cycle. Reset clears all queues and the phase; a
// full result queue stalls the back end, a full frame queue raises full.
module linear_resampler_with_volume_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [rsv_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [rsv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  rsv_pkg::sample_t               sample,
	output logic                           empty,
	input  logic                           pop,
	output rsv_pkg::result_t               result
);

	rsv_pkg::cfg_t    cfg;
	rsv_pkg::head_t   head;
	logic             head_pop;
	logic             oq_full;
	logic             oq_wr;
	rsv_pkg::result_t oq_data;

	rsv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.head     (head),
		.head_pop (head_pop)
	);

	rsv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.head     (head),
		.head_pop (head_pop),
		.oq_full  (oq_full),
		.oq_wr    (oq_wr),
		.oq_data  (oq_data)
	);

	rsv_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (oq_wr),
		.wr_data (oq_data),
		.oq_full (oq_full),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

// ----- tb/tb_linear_resampler_with_volume_top.sv -----
// tb_linear_resampler_with_volume_top: self-checking testbench of the linear resampler with volume.
// Drives frames and register writes, predicts every output sample in place and checks it.
// Depends on rsv_pkg and linear_resampler_with_volume_top.
module tb_linear_resampler_with_volume_top;

	localparam int CLK_HALF       = 6;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int MAX_REPORTS    = 10;
	localparam logic [rsv_pkg::PHASE_W-1:0] ONE_PHASE = 18'h10000;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           cfg_wen  = 1'b0;
	logic [rsv_pkg::CFG_IDX_W-1:0]  cfg_addr = rsv_pkg::REG_SOURCE_RATE;
	logic [rsv_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           push     = 1'b0;
	logic                           full;
	rsv_pkg::sample_t               frame_in = '0;
	logic                           empty;
	logic                           pop      = 1'b0;
	rsv_pkg::result_t               frame_out;

	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int mismatches    = 0;
	int frames_sent   = 0;
	int outputs_seen  = 0;
	int settings_used = 0;

	// predictor state and register copies
	logic [rsv_pkg::RATE_W-1:0]  m_rate   = rsv_pkg::RATE_RESET;
	logic [rsv_pkg::VOL_W-1:0]   m_vol    = rsv_pkg::VOL_RESET;
	logic                        m_stereo = rsv_pkg::STEREO_RESET;
	logic signed [15:0]          m_prev_l = '0;
	logic signed [15:0]          m_prev_r = '0;
	logic [rsv_pkg::PHASE_W-1:0] m_phase  = '0;
	logic                        m_primed = 1'b0;

	rsv_pkg::result_t pending_outputs[$];

	linear_resampler_with_volume_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.sample   (frame_in),
		.empty    (empty),
		.pop      (pop),
		.result   (frame_out)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	function automatic longint interp_channel(input longint a, input longint b,
			input logic [rsv_pkg::PHASE_W-1:0] frac);
		longint prod;
		prod = (b - a) * longint'(frac);
		return a + (prod >>> 16);
	endfunction

	function automatic logic [15:0] apply_volume(input longint v,
			input logic [rsv_pkg::VOLQ_W-1:0] volq);
		longint scaled;
		scaled = (v * longint'(volq)) >>> 8;
		return scaled[15:0];
	endfunction

	task automatic interpolate_frame(input rsv_pkg::sample_t s);
		logic [31:0]                 step;
		logic [rsv_pkg::VOL_W-1:0]   vol;
		logic [rsv_pkg::VOLQ_W-1:0]  volq;
		logic [rsv_pkg::PHASE_W-1:0] next_phase;
		longint                      il, ir;
		int                          n;
		rsv_pkg::result_t            r;
		step = ({15'd0, m_rate} << 12) / 32'd3000;
		vol  = (m_vol > rsv_pkg::VOL_MAX) ? rsv_pkg::VOL_MAX : m_vol;
		volq = rsv_pkg::VOLQ_W'((int'(vol) * 256) / 100);
		if (!m_primed) begin
			m_primed = 1'b1;
			m_phase  = '0;
		end else begin
			n = 0;
			while (m_phase < ONE_PHASE && n < rsv_pkg::MAX_OUT) begin
				il = interp_channel(longint'(m_prev_l), longint'(s.left_in), m_phase);
				ir = m_stereo ? interp_channel(longint'(m_prev_r), longint'(s.right_in), m_phase)
				              : il;
				next_phase    = rsv_pkg::PHASE_W'(m_phase + step);
				r.left_out    = apply_volume(il, volq);
				r.right_out   = apply_volume(ir, volq);
				r.last_of_run = !(next_phase < ONE_PHASE && n + 1 < rsv_pkg::MAX_OUT);
				pending_outputs.push_back(r);
				m_phase = next_phase;
				n++;
			end
			// a run cut short by the output limit restarts at phase zero
			if (m_phase < ONE_PHASE)
				m_phase = '0;
			else
				m_phase = m_phase - ONE_PHASE;
		end
		m_prev_l = s.left_in;
		m_prev_r = s.right_in;
	endtask

	always @(posedge clk) begin : monitor
		rsv_pkg::result_t want;
		if (arst_n) begin
			if (cfg_wen) begin
				case (cfg_addr)
					rsv_pkg::REG_SOURCE_RATE:    m_rate   = cfg_data[rsv_pkg::RATE_W-1:0];
					rsv_pkg::REG_VOLUME_PERCENT: m_vol    = cfg_data[rsv_pkg::VOL_W-1:0];
					rsv_pkg::REG_STEREO_MODE:    m_stereo = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full)
				interpolate_frame(frame_in);
			if (pop && !empty) begin
				outputs_seen++;
				if (pending_outputs.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected output L=%0d R=%0d last=%0d",
							frame_out.left_out, frame_out.right_out, frame_out.last_of_run);
				end else begin
					want = pending_outputs.pop_front();
					if (frame_out.left_out !== want.left_out ||
						frame_out.right_out !== want.right_out ||
						frame_out.last_of_run !== want.last_of_run) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: expected L=%0d R=%0d last=%0d, got L=%0d R=%0d last=%0d",
								want.left_out, want.right_out, want.last_of_run,
								frame_out.left_out, frame_out.right_out, frame_out.last_of_run);
					end
				end
			end
		end
	end

	task automatic send_frame(input logic [15:0] l, input logic [15:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push     <= 1'b1;
		frame_in <= '{left_in: l, right_in: r};
		do @(posedge clk); while (full);
		frames_sent++;
	endtask

	// hold off input until every pending output has come, then let the back end settle
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input int rate, input int vol, input logic stereo);
		wait_idle();
		@(negedge clk);
		cfg_wen  <= 1'b1;
		cfg_addr <= rsv_pkg::REG_SOURCE_RATE;
		cfg_data <= rsv_pkg::CFG_DATA_W'(rate);
		@(negedge clk);
		cfg_addr <= rsv_pkg::REG_VOLUME_PERCENT;
		cfg_data <= rsv_pkg::CFG_DATA_W'(vol);
		@(negedge clk);
		cfg_addr <= rsv_pkg::REG_STEREO_MODE;
		cfg_data <= rsv_pkg::CFG_DATA_W'(stereo);
		@(negedge clk);
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int rand_rate();
		case ($urandom_range(11))
			0:       return 0;
			1:       return 131071;
			2:       return 8000;
			3:       return 96000;
			4:       return 48000;
			5:       return $urandom_range(1, 7999);
			6:       return $urandom_range(96001, 131071);
			default: return $urandom_range(8000, 96000);
		endcase
	endfunction

	// reset values in force; first frame only primes, 48 kHz gives one output per frame
	task automatic test_priming_unity();
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h7fff);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h0000, 16'hffff);
		send_frame(16'hffff, 16'h0000);
	endtask

	task automatic test_upsample();
		write_cfg(8000, 100, 1'b1);
		send_frame(16'h8000, 16'h7fff);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h1234, 16'hedcb);
	endtask

	// rate zero and rates below 8 kHz hit the seven-output limit
	task automatic test_output_limit();
		write_cfg(0, 100, 1'b1);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h7fff);
		write_cfg(7999, 100, 1'b1);
		send_frame(16'h4000, 16'hc000);
		send_frame(16'h8000, 16'h7fff);
		write_cfg(1, 100, 1'b1);
		send_frame(16'h7fff, 16'h7fff);
	endtask

	// steps above one: some frames arrive with phase past one and emit nothing
	task automatic test_frame_skip();
		write_cfg(131071, 100, 1'b1);
		send_frame(16'h8000, 16'h7fff);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h0001, 16'hfffe);
		send_frame(16'h8000, 16'h7fff);
		write_cfg(96000, 100, 1'b1);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h7fff);
	endtask

	// zero, minimum, and above-hundred volumes
	task automatic test_volume();
		write_cfg(24000, 0, 1'b1);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h7fff);
		write_cfg(24000, 127, 1'b1);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h7fff);
		write_cfg(24000, 101, 1'b1);
		send_frame(16'h7fff, 16'h8000);
		write_cfg(24000, 1, 1'b1);
		send_frame(16'h8000, 16'h7fff);
	endtask

	// mono: right output follows left, right input still kept as previous
	task automatic test_mono();
		write_cfg(16000, 50, 1'b0);
		send_frame(16'h7fff, 16'h8000);
		send_frame(16'h8000, 16'h1234);
		send_frame(16'h0100, 16'h7fff);
	endtask

	task automatic test_random();
		int idle_tbl[4];
		int stall_tbl[4];
		idle_tbl  = '{0, 55, 0, 16};
		stall_tbl = '{0, 0, 55, 16};
		for (int p = 0; p < 4; p++) begin
			for (int k = 0; k < 24; k++) begin
				// twice per phase the sender drains completely before a new setting
				if (k % 12 == 0) begin
					send_idle_pct = 0;
					write_cfg(rand_rate(), $urandom_range(0, 127), 1'($urandom_range(1)));
					send_idle_pct = idle_tbl[p];
					pop_stall_pct = stall_tbl[p];
				end
				send_frame(rand_sample(), rand_sample());
			end
		end
		send_idle_pct = 0;
		pop_stall_pct = 0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_priming_unity();
		test_upsample();
		test_output_limit();
		test_frame_skip();
		test_volume();
		test_mono();
		test_random();
		wait_idle();
		$display("covered %0d frames over %0d register settings and four idle/stall mixes",
			frames_sent, settings_used);
		$display("checked %0d output samples, %0d mismatches", outputs_seen, mismatches);
		if (mismatches == 0)
			$display("[linear_resampler_with_volume_top] OK");
		else
			$display("[linear_resampler_with_volume_top] ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("timeout with %0d outputs still pending", pending_outputs.size());
		$display("[linear_resampler_with_volume_top] ERROR");
		$finish;
	end

endmodule
